FILE: sv/udp_receive_checksum_classifier_core_defines.svh
// Assertion macros shared by the checker of the UDP receive classifier.
`ifndef UDP_RECEIVE_CHECKSUM_CLASSIFIER_CORE_DEFINES_SVH
`define UDP_RECEIVE_CHECKSUM_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define UDPRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("udprc check failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define UDPRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("udprc check failed: next-cycle implication");

`endif

FILE: sv/udprc_pkg.sv
`default_nettype none
package udprc_pkg;

   // Register indexes of the configuration port
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ECHO_PORT    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISCARD_PORT = 1'b1;

   localparam logic [15:0] ECHO_PORT_RESET    = 16'd7;
   localparam logic [15:0] DISCARD_PORT_RESET = 16'd9;

   // Verdict codes
   localparam logic [2:0] VERDICT_ECHO      = 3'd0;
   localparam logic [2:0] VERDICT_DISCARD   = 3'd1;
   localparam logic [2:0] VERDICT_DELIVER   = 3'd2;
   localparam logic [2:0] VERDICT_CSUM_ERR  = 3'd3;
   localparam logic [2:0] VERDICT_TRUNCATED = 3'd4;

   // Byte positions within the stream (addresses start at zero)
   localparam logic [16:0] POS_SRC_PORT = 17'd9;
   localparam logic [16:0] POS_DST_PORT = 17'd11;
   localparam logic [16:0] POS_LENGTH   = 17'd13;
   localparam logic [16:0] POS_CSUM_HI  = 17'd14;
   localparam logic [16:0] POS_CSUM_LO  = 17'd15;
   localparam logic [16:0] POS_HDR_END  = 17'd16;
   localparam logic [16:0] POS_MAX      = 17'h1ffff;
   localparam logic [17:0] ADDR_BYTES   = 18'd8;

   localparam logic [31:0] SUM_RESET = 32'd17;   // protocol number in pseudo header

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [15:0] udp_length;
      logic [15:0] computed_checksum;
      logic        checksum_present;
   } rsp_type;

   // Finished packet handed from the accumulator to the classifier
   typedef struct packed {
      logic [31:0] sum;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] length;
      logic [15:0] rx_checksum;
      logic        truncated;
   } fin_type;

endpackage
`default_nettype wire

FILE: sv/udprc_accum.sv
`default_nettype none
module udprc_accum (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire udprc_pkg::req_type in_data,
   input  wire logic              fin_take,
   output      logic              in_take,
   output      logic              fin_valid,
   output      udprc_pkg::fin_type fin_data
);

   logic [16:0] pos_ff, pos_in;
   logic [31:0] sum_ff, sum_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] rxc_ff, rxc_in;
   logic        fin_valid_ff, fin_valid_in;
   udprc_pkg::fin_type fin_data_ff;

   logic        odd;
   logic [15:0] word;
   logic [17:0] len_end;
   logic [17:0] count;
   logic        summed;
   logic        use_byte;
   logic [31:0] add_len;
   logic [31:0] add_byte;
   logic        truncated;

   assign in_take = in_valid && (!in_data.last_byte || !fin_valid_ff || fin_take);

   always_comb begin
      odd      = pos_ff[0];
      word     = {held_ff, in_data.data_byte};
      held_in  = odd ? held_ff : in_data.data_byte;
      src_in   = (pos_ff == udprc_pkg::POS_SRC_PORT) ? word : src_ff;
      dst_in   = (pos_ff == udprc_pkg::POS_DST_PORT) ? word : dst_ff;
      len_in   = (pos_ff == udprc_pkg::POS_LENGTH)   ? word : len_ff;
      rxc_in   = (pos_ff == udprc_pkg::POS_CSUM_LO)  ? word : rxc_ff;
      len_end  = {2'b00, len_in} + udprc_pkg::ADDR_BYTES;
      summed   = (pos_ff < udprc_pkg::POS_HDR_END) || ({1'b0, pos_ff} < len_end);
      use_byte = summed && (pos_ff != udprc_pkg::POS_CSUM_HI)
                 && (pos_ff != udprc_pkg::POS_CSUM_LO);
      // length enters the pseudo header as well as the header proper
      add_len  = (pos_ff == udprc_pkg::POS_LENGTH) ? {16'd0, word} : 32'd0;
      add_byte = !use_byte ? 32'd0 :
                 odd       ? {24'd0, in_data.data_byte} :
                             {16'd0, in_data.data_byte, 8'd0};
      sum_in   = sum_ff + add_len + add_byte;
      count    = {1'b0, pos_ff} + 18'd1;
      truncated = (count < {1'b0, udprc_pkg::POS_HDR_END}) || (count < len_end);
      pos_in   = (pos_ff == udprc_pkg::POS_MAX) ? pos_ff : pos_ff + 17'd1;

      if (in_take && in_data.last_byte) begin
         fin_valid_in = 1'b1;
      end else if (fin_take) begin
         fin_valid_in = 1'b0;
      end else begin
         fin_valid_in = fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 17'd0;
         sum_ff       <= udprc_pkg::SUM_RESET;
         held_ff      <= 8'd0;
         src_ff       <= 16'd0;
         dst_ff       <= 16'd0;
         len_ff       <= 16'd0;
         rxc_ff       <= 16'd0;
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         if (in_take) begin
            if (in_data.last_byte) begin
               // packet done: back to the clear state
               pos_ff  <= 17'd0;
               sum_ff  <= udprc_pkg::SUM_RESET;
               held_ff <= 8'd0;
               src_ff  <= 16'd0;
               dst_ff  <= 16'd0;
               len_ff  <= 16'd0;
               rxc_ff  <= 16'd0;
            end else begin
               pos_ff  <= pos_in;
               sum_ff  <= sum_in;
               held_ff <= held_in;
               src_ff  <= src_in;
               dst_ff  <= dst_in;
               len_ff  <= len_in;
               rxc_ff  <= rxc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_data.last_byte) begin
         fin_data_ff.sum         <= sum_in;
         fin_data_ff.sport       <= src_in;
         fin_data_ff.dport       <= dst_in;
         fin_data_ff.length      <= len_in;
         fin_data_ff.rx_checksum <= rxc_in;
         fin_data_ff.truncated   <= truncated;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin_data  = fin_data_ff;

endmodule
`default_nettype wire

FILE: sv/udprc_finish.sv
`default_nettype none
module udprc_finish (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fin_valid,
   input  wire udprc_pkg::fin_type fin_data,
   input  wire logic [15:0]        echo_port,
   input  wire logic [15:0]        discard_port,
   input  wire logic               rsp_stall,
   output      logic               fin_take,
   output      logic               rsp_valid,
   output      udprc_pkg::rsp_type rsp_data
);

   logic               rsp_valid_ff, rsp_valid_in;
   udprc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] computed;
   logic        present;
   logic        csum_bad;

   assign fin_take = fin_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      // fold carries twice, then invert
      fold1    = {1'b0, fin_data.sum[31:16]} + {1'b0, fin_data.sum[15:0]};
      fold2    = fold1[15:0] + {15'd0, fold1[16]};
      computed = ~fold2;
      present  = (fin_data.rx_checksum != 16'd0);
      // all ones received stands for a computed zero
      csum_bad = present && (fin_data.rx_checksum != computed)
                 && !((computed == 16'd0) && (fin_data.rx_checksum == 16'hffff));

      rsp_data_in.source_port       = fin_data.sport;
      rsp_data_in.destination_port  = fin_data.dport;
      rsp_data_in.udp_length        = fin_data.length;
      rsp_data_in.checksum_present  = present;
      rsp_data_in.computed_checksum = fin_data.truncated ? 16'd0 : computed;
      if (fin_data.truncated) begin
         rsp_data_in.verdict = udprc_pkg::VERDICT_TRUNCATED;
      end else if (csum_bad) begin
         rsp_data_in.verdict = udprc_pkg::VERDICT_CSUM_ERR;
      end else if (fin_data.dport == echo_port) begin
         rsp_data_in.verdict = udprc_pkg::VERDICT_ECHO;
      end else if (fin_data.dport == discard_port) begin
         rsp_data_in.verdict = udprc_pkg::VERDICT_DISCARD;
      end else begin
         rsp_data_in.verdict = udprc_pkg::VERDICT_DELIVER;
      end

      rsp_valid_in = fin_take || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: sv/udp_receive_checksum_classifier_core.sv
// After its last byte, a packet passes the input register and the finished-packet register into the response register.
// Throughput: one byte per cycle while req_stall is low; the running-sum register loops once per byte.
// A finished packet waits in its own register, so bytes keep flowing while a
// response is stalled, until a second finished packet would need that register.
// Reset (synchronous, active high) clears all packet state and sets the port
// registers to echo 7 and discard 9.
`default_nettype none
module udp_receive_checksum_classifier_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output      logic                                    req_stall,
   input  wire udprc_pkg::req_type                      req_data,
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_stall,
   output      udprc_pkg::rsp_type                      rsp_data,
   input  wire logic                                    csr_write,
   input  wire logic [udprc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [15:0]                             csr_wdata
);

   // Input register: holds one request until the accumulator takes it
   logic               in_valid_ff, in_valid_in;
   udprc_pkg::req_type in_data_ff;

   // Port registers
   logic [15:0] echo_port_ff;
   logic [15:0] discard_port_ff;

   logic               in_take;
   logic               fin_valid;
   logic               fin_take;
   udprc_pkg::fin_type fin_data;

   // Stall only while a held request cannot move on this cycle
   assign req_stall   = in_valid_ff && !in_take;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Configuration writes must arrive only while the block is idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_port_ff    <= udprc_pkg::ECHO_PORT_RESET;
         discard_port_ff <= udprc_pkg::DISCARD_PORT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            udprc_pkg::CSR_ECHO_PORT:    echo_port_ff    <= csr_wdata;
            udprc_pkg::CSR_DISCARD_PORT: discard_port_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Accumulate: header capture, running sum, byte count; hand over on last byte
   udprc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_data   (in_data_ff),
      .fin_take  (fin_take),
      .in_take   (in_take),
      .fin_valid (fin_valid),
      .fin_data  (fin_data)
   );

   // Fold, check and classify into the response register
   udprc_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .fin_valid    (fin_valid),
      .fin_data     (fin_data),
      .echo_port    (echo_port_ff),
      .discard_port (discard_port_ff),
      .rsp_stall    (rsp_stall),
      .fin_take     (fin_take),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire

FILE: sv/udprc_checker.sv
`default_nettype none
`include "udp_receive_checksum_classifier_core_defines.svh"
module udprc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire udprc_pkg::rsp_type rsp_data
);

   logic rsp_held;
   logic rsp_trunc;
   logic rsp_no_csum;
   logic rsp_code_ok;
   logic rsp_not_err;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_trunc   = rsp_valid && (rsp_data.verdict == udprc_pkg::VERDICT_TRUNCATED);
   assign rsp_no_csum = rsp_valid && !rsp_data.checksum_present;
   assign rsp_code_ok = (rsp_data.verdict <= udprc_pkg::VERDICT_TRUNCATED);
   assign rsp_not_err = (rsp_data.verdict != udprc_pkg::VERDICT_CSUM_ERR);

   // A stalled response holds
   `UDPRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // No response right after reset
   `UDPRC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // Verdict stays within its codes
   `UDPRC_ASSERT_IMPLY(a_verdict_range, clock, reset, rsp_valid, rsp_code_ok)

   // Truncated packets report no checksum
   `UDPRC_ASSERT_IMPLY(a_trunc_zero, clock, reset, rsp_trunc, rsp_data.computed_checksum == 16'd0)

   // Without a received checksum there is nothing to fail
   `UDPRC_ASSERT_IMPLY(a_no_csum_no_err, clock, reset, rsp_no_csum, rsp_not_err)

endmodule

bind udp_receive_checksum_classifier_core udprc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: dv/udp_receive_checksum_classifier_core_tb.sv
`timescale 1ns / 100ps
module udp_receive_checksum_classifier_core_tb;

   // Cycles with neither a request nor a response accepted before the run is abandoned
   localparam int unsigned QUIET_LIMIT = 4000;
   // Settling time after the last response
   localparam int unsigned SETTLE_CYCLES = 8;

   // Kinds of packet the stimulus builds
   typedef enum int {
      PK_GOOD,
      PK_NO_CSUM,
      PK_BAD_CSUM,
      PK_TRAILING,
      PK_SHORT_LEN,
      PK_TRUNCATED,
      PK_ZERO_SUM,
      PK_NOISE
   } pkt_kind_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   udprc_pkg::req_type                    req_data = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   udprc_pkg::rsp_type                    rsp_data;
   logic                                  csr_write = 1'b0;
   logic [udprc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [15:0]                           csr_wdata = '0;

   udprc_pkg::req_type pending_requests[$];
   udprc_pkg::rsp_type expected_reports[$];
   logic [7:0]         pkt_bytes[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned bytes_queued = 0;
   int unsigned quiet_cycles = 0;
   int          failures = 0;

   // Mirror of the block: port registers and the packet in progress
   logic [15:0] echo_port_cfg;
   logic [15:0] discard_port_cfg;
   logic [16:0] pkt_pos;
   logic [31:0] pkt_sum;
   logic [7:0]  pkt_hi;
   logic [15:0] pkt_src;
   logic [15:0] pkt_dst;
   logic [15:0] pkt_len;
   logic [15:0] pkt_rx_csum;

   udp_receive_checksum_classifier_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Return the packet state to its idle values; the port registers stay.
   task automatic clear_packet();
      pkt_pos     = '0;
      pkt_sum     = udprc_pkg::SUM_RESET;
      pkt_hi      = '0;
      pkt_src     = '0;
      pkt_dst     = '0;
      pkt_len     = '0;
      pkt_rx_csum = '0;
   endtask

   // Advance the mirror by one accepted byte; on the last byte of a packet
   // queue the report the block should give.
   task automatic classify_byte(input udprc_pkg::req_type r);
      int unsigned        p;
      logic [15:0]        word;
      logic [31:0]        fold;
      udprc_pkg::rsp_type rep;
      p    = pkt_pos;
      word = {pkt_hi, r.data_byte};

      // capture header words as their low byte arrives
      if (!pkt_pos[0]) begin
         pkt_hi = r.data_byte;
      end else begin
         case (pkt_pos)
            udprc_pkg::POS_SRC_PORT: pkt_src = word;
            udprc_pkg::POS_DST_PORT: pkt_dst = word;
            udprc_pkg::POS_LENGTH: begin
               pkt_len = word;
               pkt_sum = pkt_sum + word;   // length counted again in the pseudo header
            end
            udprc_pkg::POS_CSUM_LO: pkt_rx_csum = word;
            default: ;
         endcase
      end

      // sum everything up to the end of the header or of the datagram,
      // whichever is later, with the received checksum taken as zero
      if ((p < udprc_pkg::POS_HDR_END || p < udprc_pkg::ADDR_BYTES + pkt_len) &&
          pkt_pos != udprc_pkg::POS_CSUM_HI && pkt_pos != udprc_pkg::POS_CSUM_LO) begin
         pkt_sum = pkt_sum + (p[0] ? {24'h0, r.data_byte} : {16'h0, r.data_byte, 8'h0});
      end

      if (pkt_pos != udprc_pkg::POS_MAX)
         pkt_pos = pkt_pos + 1'b1;

      if (r.last_byte) begin
         rep.source_port       = pkt_src;
         rep.destination_port  = pkt_dst;
         rep.udp_length        = pkt_len;
         rep.checksum_present  = (pkt_rx_csum != 16'h0);
         rep.computed_checksum = 16'h0;
         if (p + 1 < udprc_pkg::POS_HDR_END || p + 1 < udprc_pkg::ADDR_BYTES + pkt_len) begin
            rep.verdict = udprc_pkg::VERDICT_TRUNCATED;
         end else begin
            fold = {16'h0, pkt_sum[31:16]} + {16'h0, pkt_sum[15:0]};
            fold = fold + {16'h0, fold[31:16]};
            rep.computed_checksum = ~fold[15:0];
            // all ones is the other spelling of a zero checksum
            if (rep.checksum_present && pkt_rx_csum != rep.computed_checksum &&
                !(rep.computed_checksum == 16'h0 && pkt_rx_csum == 16'hffff))
               rep.verdict = udprc_pkg::VERDICT_CSUM_ERR;
            else if (pkt_dst == echo_port_cfg)
               rep.verdict = udprc_pkg::VERDICT_ECHO;
            else if (pkt_dst == discard_port_cfg)
               rep.verdict = udprc_pkg::VERDICT_DISCARD;
            else
               rep.verdict = udprc_pkg::VERDICT_DELIVER;
         end
         expected_reports.push_back(rep);
         clear_packet();
      end
   endtask

   task automatic flag_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      failures++;
   endtask

   // Compare one accepted response with the oldest outstanding report.
   task automatic check_report(input udprc_pkg::rsp_type got);
      udprc_pkg::rsp_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: response with none expected, expected nothing, actual %h",
                  $time, got);
         failures++;
      end else begin
         want = expected_reports.pop_front();
         if (got.verdict !== want.verdict)
            flag_mismatch("verdict", 16'(want.verdict), 16'(got.verdict));
         if (got.source_port !== want.source_port)
            flag_mismatch("source_port", want.source_port, got.source_port);
         if (got.destination_port !== want.destination_port)
            flag_mismatch("destination_port", want.destination_port, got.destination_port);
         if (got.udp_length !== want.udp_length)
            flag_mismatch("udp_length", want.udp_length, got.udp_length);
         if (got.computed_checksum !== want.computed_checksum)
            flag_mismatch("computed_checksum", want.computed_checksum,
                          got.computed_checksum);
         if (got.checksum_present !== want.checksum_present)
            flag_mismatch("checksum_present", 16'(want.checksum_present),
                          16'(got.checksum_present));
      end
   endtask

   // ------------------------------------------------------------------
   // Driver, receiver and monitor
   // ------------------------------------------------------------------

   // Hold a stalled request; otherwise take the next one unless the sender idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Track register writes, predict on accepted requests, check accepted
   // responses, and abandon the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         echo_port_cfg    = udprc_pkg::ECHO_PORT_RESET;
         discard_port_cfg = udprc_pkg::DISCARD_PORT_RESET;
         clear_packet();
         quiet_cycles <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               udprc_pkg::CSR_ECHO_PORT:    echo_port_cfg = csr_wdata;
               udprc_pkg::CSR_DISCARD_PORT: discard_port_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            classify_byte(req_data);
         if (rsp_valid && !rsp_stall)
            check_report(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or response accepted for %0d cycles",
                     $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic set_word(input int unsigned at, input logic [15:0] w);
      pkt_bytes[at]     = w[15:8];
      pkt_bytes[at + 1] = w[7:0];
   endtask

   // Inverted folded sum of the first n bytes of the packet under construction.
   function automatic logic [15:0] folded_checksum(input int unsigned n);
      logic [31:0] acc;
      logic [15:0] len;
      int unsigned span;
      len  = (n > udprc_pkg::POS_LENGTH) ? {pkt_bytes[12], pkt_bytes[13]} : 16'h0;
      acc  = udprc_pkg::SUM_RESET + len;
      span = udprc_pkg::ADDR_BYTES + len;
      if (span < udprc_pkg::POS_HDR_END)
         span = udprc_pkg::POS_HDR_END;
      for (int unsigned i = 0; i < n && i < span; i++) begin
         if (i != udprc_pkg::POS_CSUM_HI && i != udprc_pkg::POS_CSUM_LO)
            acc = acc + (i[0] ? {24'h0, pkt_bytes[i]} : {16'h0, pkt_bytes[i], 8'h0});
      end
      acc = {16'h0, acc[31:16]} + {16'h0, acc[15:0]};
      acc = acc + {16'h0, acc[31:16]};
      return ~acc[15:0];
   endfunction

   // Favour the configured ports so every verdict turns up often.
   function automatic logic [15:0] pick_dst();
      case ($urandom_range(9))
         0, 1, 2: return echo_port_cfg;
         3, 4:    return discard_port_cfg;
         5:       return 16'h0000;
         6:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Send the first n bytes of the packet, the last one marked.
   task automatic queue_packet(input int unsigned n);
      udprc_pkg::req_type r;
      for (int unsigned i = 0; i < n; i++) begin
         r.data_byte = pkt_bytes[i];
         r.last_byte = (i == n - 1);
         pending_requests.push_back(r);
      end
      bytes_queued += n;
   endtask

   task automatic build_packet(input pkt_kind_type kind, input int unsigned plen,
                               input logic [15:0] dst);
      logic [15:0] good_sum;
      int unsigned total;
      pkt_bytes.delete();
      if (kind == PK_NOISE) begin
         repeat ($urandom_range(40, 1)) pkt_bytes.push_back(8'($urandom));
         queue_packet(pkt_bytes.size());
         return;
      end
      repeat (8) pkt_bytes.push_back(8'($urandom));
      repeat (8) pkt_bytes.push_back(8'h00);
      set_word(8, ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom));
      set_word(10, dst);
      set_word(12, 16'(8 + plen));
      repeat (plen) pkt_bytes.push_back(8'($urandom));
      if (kind == PK_SHORT_LEN) begin
         // length below the header size: nothing past the header is summed
         set_word(12, 16'($urandom_range(7)));
         repeat ($urandom_range(5)) pkt_bytes.push_back(8'($urandom));
      end
      total = pkt_bytes.size();
      if (kind == PK_ZERO_SUM) begin
         // choose the final word so the folded sum comes out all ones
         set_word(total - 2, 16'h0);
         set_word(total - 2, folded_checksum(total));
      end
      good_sum = folded_checksum(total);
      case (kind)
         PK_NO_CSUM:  set_word(14, 16'h0);
         PK_BAD_CSUM: set_word(14, good_sum ^ 16'($urandom_range(65535, 1)));
         PK_ZERO_SUM: set_word(14, 16'hffff);
         default:     set_word(14, good_sum);
      endcase
      if (kind == PK_TRAILING)
         repeat ($urandom_range(6, 1)) pkt_bytes.push_back(8'($urandom));
      if (kind == PK_TRUNCATED)
         total = $urandom_range(total - 1, 1);
      else
         total = pkt_bytes.size();
      queue_packet(total);
   endtask

   // Mostly well-formed datagrams with random content, the rest broken or noise.
   task automatic fill_random(input int unsigned amount);
      int unsigned  start;
      int unsigned  roll;
      int unsigned  plen;
      pkt_kind_type kind;
      start = bytes_queued;
      while (bytes_queued - start < amount) begin
         roll = $urandom_range(99);
         if (roll < 40)      kind = PK_GOOD;
         else if (roll < 52) kind = PK_NO_CSUM;
         else if (roll < 62) kind = PK_BAD_CSUM;
         else if (roll < 72) kind = PK_TRAILING;
         else if (roll < 78) kind = PK_SHORT_LEN;
         else if (roll < 88) kind = PK_TRUNCATED;
         else if (roll < 94) kind = PK_ZERO_SUM;
         else                kind = PK_NOISE;
         plen = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(20);
         if (kind == PK_ZERO_SUM)
            plen = 2 * $urandom_range(10, 1);
         build_packet(kind, plen, pick_dst());
      end
   endtask

   // Hold until every request is taken and every report has come back,
   // then give the block time to settle.
   task automatic wait_for_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_port(input logic [udprc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                               input logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      logic [15:0] shared_port;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver stalls heavily; ports at reset values.
      send_idle_pct  = 28;
      recv_stall_pct = 60;
      @(negedge clock);
      build_packet(PK_GOOD, 0, echo_port_cfg);        // shortest complete datagram
      build_packet(PK_GOOD, 1, discard_port_cfg);     // odd payload, padded low byte
      build_packet(PK_ZERO_SUM, 2, 16'h1234);         // all-ones checksum accepted
      build_packet(PK_SHORT_LEN, 0, 16'h0);
      build_packet(PK_BAD_CSUM, 3, echo_port_cfg);
      build_packet(PK_TRAILING, 2, 16'hffff);
      pkt_bytes = '{8'hff};                           // stream ends on its first byte
      queue_packet(1);
      pkt_bytes.delete();
      repeat (16) pkt_bytes.push_back(8'h00);         // zero length, no checksum
      queue_packet(16);
      pkt_bytes.delete();
      repeat (20) pkt_bytes.push_back(8'hff);         // maximum length, ends early
      queue_packet(20);
      fill_random(250);
      wait_for_idle();

      // Extremes of both port registers.
      program_port(udprc_pkg::CSR_ECHO_PORT, 16'h0000);
      program_port(udprc_pkg::CSR_DISCARD_PORT, 16'hffff);
      @(negedge clock);
      fill_random(200);
      wait_for_idle();

      // Swap the idling; one port in both registers, so echo must win.
      send_idle_pct  = 60;
      recv_stall_pct = 28;
      shared_port = 16'($urandom);
      program_port(udprc_pkg::CSR_ECHO_PORT, shared_port);
      program_port(udprc_pkg::CSR_DISCARD_PORT, shared_port);
      @(negedge clock);
      fill_random(250);
      wait_for_idle();

      program_port(udprc_pkg::CSR_ECHO_PORT, 16'hffff);
      program_port(udprc_pkg::CSR_DISCARD_PORT, 16'h0000);
      @(negedge clock);
      fill_random(200);
      wait_for_idle();

      // Full rate both ways, random ports.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      program_port(udprc_pkg::CSR_ECHO_PORT, 16'($urandom));
      program_port(udprc_pkg::CSR_DISCARD_PORT, 16'($urandom));
      @(negedge clock);
      fill_random(300);
      wait_for_idle();

      if (expected_reports.size() != 0) begin
         $display("%0t: %0d reports never arrived", $time, expected_reports.size());
         failures++;
      end
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/udprc_pkg.sv
sv/udprc_accum.sv
sv/udprc_finish.sv
sv/udp_receive_checksum_classifier_core.sv
sv/udprc_checker.sv
dv/udp_receive_checksum_classifier_core_tb.sv
